// ===== design/wdg_pkg.sv =====
// ---------------------------------------------------------------------------
// wdg_pkg: shared types and constants for the task watchdog
// Field widths, action codes, controller states and slot table control.
// ---------------------------------------------------------------------------
`default_nettype none

package wdg_pkg;

  // Fixed payload widths
  localparam int ACTION_W  = 2;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;

  // Reset value of the scan period register
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REGISTER = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FEED     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNREG    = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  // Slot table write controls
  typedef struct packed {
    logic reg_en;
    logic feed_en;
    logic unreg_en;
  } tbl_ctrl_t;

  // Slot table status
  typedef struct packed {
    logic free_found;
    logic hit;
  } tbl_stat_t;

endpackage

`default_nettype wire

// ===== design/wdg_in_if.sv =====
// ---------------------------------------------------------------------------
// wdg_in_if: command channel of the task watchdog
// Carries valid, ready and one command item (action, slot, timeout).
// ---------------------------------------------------------------------------
`default_nettype none

interface wdg_in_if;
  import wdg_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot;
  logic [TIME_W-1:0]   timeout;

  modport source (output valid, action, slot, timeout, input ready);
  modport sink   (input valid, action, slot, timeout, output ready);
endinterface

`default_nettype wire

// ===== design/wdg_out_if.sv =====
// ---------------------------------------------------------------------------
// wdg_out_if: response channel of the task watchdog
// Carries valid, ready and one response item.
// ---------------------------------------------------------------------------
`default_nettype none

interface wdg_out_if;
  import wdg_pkg::*;

  logic              valid;
  logic              ready;
  logic              register_ok;
  logic [SLOT_W-1:0] assigned_slot;
  logic              expired;
  logic [SLOT_W-1:0] expired_slot;
  logic [TIME_W-1:0] expired_elapsed;

  modport source (output valid, register_ok, assigned_slot, expired, expired_slot,
                  expired_elapsed, input ready);
  modport sink   (input valid, register_ok, assigned_slot, expired, expired_slot,
                  expired_elapsed, output ready);
endinterface

`default_nettype wire

// ===== design/multi_slot_task_watchdog.sv =====
// ---------------------------------------------------------------------------
// multi_slot_task_watchdog: multi-slot software task watchdog
// Millisecond tick counter, periodic scan of active slots for expiry,
// register / feed / unregister of slots.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    action, slot, timeout
//   rsp      out  valid/ready    register_ok, assigned_slot, expired,
//                                expired_slot, expired_elapsed
//   cfg      in   cfg_we         cfg_wdata (check_period)
//
// Register, feed, unregister and a tick without a scan respond in the next cycle.
// A scanning tick reads the slots one per cycle through the single read port
// of each slot RAM, ending early on a hit.
// One command is in flight at a time; cmd.ready is low during a scan and
// while an undelivered response is not being taken.
// Reset clears the counters and active flags at once; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_slot_task_watchdog #(
  parameter  int SLOTS = 16,
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  wdg_in_if.sink                             cmd,
  wdg_out_if.source                          rsp,
  input  wire logic                          cfg_we,
  input  wire logic [wdg_pkg::PERIOD_W-1:0]  cfg_wdata
);
  import wdg_pkg::*;

  state_t            state;
  logic [PERIOD_W-1:0] check_period;
  logic [TIME_W-1:0] now_count;
  logic [PERIOD_W-1:0] period_count;
  logic [PERIOD_W-1:0] period_next;
  logic [SW-1:0]     scan_idx;
  logic [SW-1:0]     ev_idx;
  logic              ev_valid;

  logic              out_valid;
  logic              out_register_ok;
  logic [SLOT_W-1:0] out_assigned_slot;
  logic              out_expired;
  logic [SLOT_W-1:0] out_expired_slot;
  logic [TIME_W-1:0] out_expired_elapsed;

  logic              accept;
  logic              in_range;
  logic              scan_due;
  logic              scan_last;
  tbl_ctrl_t         ctrl;
  tbl_stat_t         stat;
  logic [SW-1:0]     free_idx;
  logic [TIME_W-1:0] elapsed;

  // Input handshake
  assign cmd.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign in_range  = 32'(cmd.slot) < SLOTS;

  // Scan scheduling
  assign period_next = period_count + 1'b1;
  assign scan_due    = period_next >= check_period;
  assign scan_last   = ev_valid && (ev_idx == SW'(SLOTS - 1));

  // Slot table controls
  assign ctrl.reg_en   = accept && (cmd.action == ACT_REGISTER);
  assign ctrl.feed_en  = accept && (cmd.action == ACT_FEED) && in_range;
  assign ctrl.unreg_en = accept && (cmd.action == ACT_UNREG) && in_range;

  wdg_slot_table #(.SLOTS(SLOTS)) u_table (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cmd_idx     (SW'(cmd.slot)),
    .cmd_timeout (cmd.timeout),
    .now         (now_count),
    .scan_addr   (scan_idx),
    .eval_idx    (ev_idx),
    .stat        (stat),
    .free_idx    (free_idx),
    .elapsed     (elapsed)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      check_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      check_period <= cfg_wdata;
    end
  end

  // Controller, counters and scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      now_count    <= '0;
      period_count <= '0;
      scan_idx     <= '0;
      ev_idx       <= '0;
      ev_valid     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (cmd.action == ACT_TICK)) begin
            now_count <= now_count + 1'b1;
            if (scan_due) begin
              period_count <= '0;
              scan_idx     <= '0;
              ev_valid     <= 1'b0;
              state        <= ST_SCAN;
            end else begin
              period_count <= period_next;
            end
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          ev_idx   <= scan_idx;
          ev_valid <= 1'b1;
          if ((ev_valid && stat.hit) || scan_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && !((cmd.action == ACT_TICK) && scan_due)) ||
                 ((state == ST_SCAN) && ((ev_valid && stat.hit) || scan_last))) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_register_ok     <= ctrl.reg_en && stat.free_found;
      out_assigned_slot   <= (ctrl.reg_en && stat.free_found) ? SLOT_W'(free_idx) : '0;
      out_expired         <= 1'b0;
      out_expired_slot    <= '0;
      out_expired_elapsed <= '0;
    end else if ((state == ST_SCAN) && ev_valid && stat.hit) begin
      out_register_ok     <= 1'b0;
      out_assigned_slot   <= '0;
      out_expired         <= 1'b1;
      out_expired_slot    <= SLOT_W'(ev_idx);
      out_expired_elapsed <= elapsed;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.register_ok     = out_register_ok;
  assign rsp.assigned_slot   = out_assigned_slot;
  assign rsp.expired         = out_expired;
  assign rsp.expired_slot    = out_expired_slot;
  assign rsp.expired_elapsed = out_expired_elapsed;

  // Checks
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.register_ok && rsp.expired))
    else $error("response flags both register and expiry");

  a_quick_resp: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.action != ACT_TICK)) |=> (rsp.valid && (state == ST_IDLE)))
    else $error("non-tick command did not respond in one cycle");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.register_ok) |-> ((SLOTS > 16) || (32'(rsp.assigned_slot) < SLOTS)))
    else $error("assigned slot out of range");

  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !ctrl.reg_en && !ctrl.feed_en && !ctrl.unreg_en)
    else $error("slot table written during scan");

endmodule

`default_nettype wire

// ===== design/wdg_ram.sv =====
// ---------------------------------------------------------------------------
// wdg_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module wdg_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/wdg_slot_table.sv =====
// ---------------------------------------------------------------------------
// wdg_slot_table: per-slot state of the watchdog
// Active flags in flops, timeout and last-fed stamps in two RAMs, free slot
// search and the expiry compare on the registered RAM outputs.
// ---------------------------------------------------------------------------
`default_nettype none

module wdg_slot_table #(
  parameter  int SLOTS = 16,
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire wdg_pkg::tbl_ctrl_t        ctrl,
  input  wire logic [SW-1:0]             cmd_idx,
  input  wire logic [wdg_pkg::TIME_W-1:0] cmd_timeout,
  input  wire logic [wdg_pkg::TIME_W-1:0] now,
  input  wire logic [SW-1:0]             scan_addr,
  input  wire logic [SW-1:0]             eval_idx,
  output wdg_pkg::tbl_stat_t             stat,
  output logic      [SW-1:0]             free_idx,
  output logic      [wdg_pkg::TIME_W-1:0] elapsed
);
  import wdg_pkg::*;

  logic [SLOTS-1:0]  active;
  logic              free_found;
  logic              to_we;
  logic              lf_we;
  logic [SW-1:0]     lf_waddr;
  logic [TIME_W-1:0] to_q;
  logic [TIME_W-1:0] lf_q;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // RAM write controls: register writes both, feed only the stamp
  assign to_we    = ctrl.reg_en && free_found;
  assign lf_we    = to_we || (ctrl.feed_en && active[cmd_idx]);
  assign lf_waddr = ctrl.reg_en ? free_idx : cmd_idx;

  // Active flags
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      if (to_we) begin
        active[free_idx] <= 1'b1;
      end
      if (ctrl.unreg_en) begin
        active[cmd_idx] <= 1'b0;
      end
    end
  end

  wdg_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_timeout_ram (
    .clk   (clk),
    .we    (to_we),
    .waddr (free_idx),
    .wdata (cmd_timeout),
    .raddr (scan_addr),
    .rdata (to_q)
  );

  wdg_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_last_fed_ram (
    .clk   (clk),
    .we    (lf_we),
    .waddr (lf_waddr),
    .wdata (now),
    .raddr (scan_addr),
    .rdata (lf_q)
  );

  // Expiry compare on the slot read last cycle (wrapping difference)
  assign elapsed         = now - lf_q;
  assign stat.hit        = active[eval_idx] && (elapsed > to_q);
  assign stat.free_found = free_found;

endmodule

`default_nettype wire

// ===== sim/tb_multi_slot_task_watchdog.sv =====
// ---------------------------------------------------------------------------
// tb_multi_slot_task_watchdog: self-checking bench for the task watchdog
// Drives ticks, registers, feeds and unregisters over the command channel,
// predicts every response with a cycle-free model of the slot table and
// compares each response transfer field by field. A directed table comes
// first, then random phases across several scan periods, with random gaps
// and stalls on both channels, a long receiver hold-off and drain pauses.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_multi_slot_task_watchdog;
  import wdg_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 64;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 105;

  // One response item as the block reports it
  typedef struct packed {
    logic              register_ok;
    logic [SLOT_W-1:0] assigned_slot;
    logic              expired;
    logic [SLOT_W-1:0] expired_slot;
    logic [TIME_W-1:0] expired_elapsed;
  } watch_result_t;

  // One row of the directed table: a period write or a repeated command
  typedef struct packed {
    logic                is_cfg;
    logic [PERIOD_W-1:0] period;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   timeout;
    logic [7:0]          reps;
    logic                typed;
    watch_result_t       want;
  } stim_row_t;

  localparam watch_result_t NO_EVENT = '0;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  wdg_in_if  cmd_if ();
  wdg_out_if rsp_if ();

  multi_slot_task_watchdog #(.SLOTS(NUM_SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Watchdog model state
  logic [TIME_W-1:0]   now_ms;
  logic [PERIOD_W-1:0] ticks_since_scan;
  logic [PERIOD_W-1:0] scan_period;
  bit                  live [NUM_SLOTS];
  logic [TIME_W-1:0]   limit_ticks [NUM_SLOTS];
  logic [TIME_W-1:0]   fed_at [NUM_SLOTS];

  watch_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int            error_count;
  bit            steady;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one command to the model and return the response it causes
  function automatic watch_result_t predict_response(logic [ACTION_W-1:0] a,
                                                     logic [SLOT_W-1:0] s,
                                                     logic [TIME_W-1:0] t);
    watch_result_t r;
    logic [TIME_W-1:0] el;
    bit hit;
    int i;
    r = '0;
    hit = 0;
    case (a)
      ACT_TICK: begin
        // counter first; the scan sees the new time
        now_ms = now_ms + 1;
        ticks_since_scan = ticks_since_scan + 1;
        if (ticks_since_scan >= scan_period) begin
          ticks_since_scan = '0;
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (!hit && live[i]) begin
              el = now_ms - fed_at[i];
              if (el > limit_ticks[i]) begin
                hit = 1;
                r.expired = 1'b1;
                r.expired_slot = SLOT_W'(i);
                r.expired_elapsed = el;
              end
            end
          end
        end
      end
      ACT_REGISTER: begin
        // lowest free slot; nothing happens on a full table
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!hit && !live[i]) begin
            hit = 1;
            live[i] = 1;
            limit_ticks[i] = t;
            fed_at[i] = now_ms;
            r.register_ok = 1'b1;
            r.assigned_slot = SLOT_W'(i);
          end
        end
      end
      ACT_FEED: begin
        if (live[s]) fed_at[s] = now_ms;
      end
      default: begin
        live[s] = 0;
      end
    endcase
    return r;
  endfunction

  function automatic watch_result_t granted(logic [SLOT_W-1:0] s);
    watch_result_t r;
    r = '0;
    r.register_ok = 1'b1;
    r.assigned_slot = s;
    return r;
  endfunction

  function automatic stim_row_t row(logic is_cfg, logic [PERIOD_W-1:0] per,
                                    logic [ACTION_W-1:0] a, logic [SLOT_W-1:0] s,
                                    logic [TIME_W-1:0] t, logic [7:0] reps,
                                    logic typed, watch_result_t want);
    stim_row_t r;
    r.is_cfg = is_cfg;
    r.period = per;
    r.action = a;
    r.slot = s;
    r.timeout = t;
    r.reps = reps;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Offer one command, wait for its transfer, queue its expected response
  task automatic send_cmd(logic [ACTION_W-1:0] a, logic [SLOT_W-1:0] s,
                          logic [TIME_W-1:0] t, bit typed, watch_result_t want);
    watch_result_t model_r;
    // idle cycle by cycle with junk on the payload
    while (!steady && $urandom_range(99) < 36) begin
      cmd_if.valid   <= 1'b0;
      cmd_if.action  <= ACTION_W'($urandom);
      cmd_if.slot    <= SLOT_W'($urandom);
      cmd_if.timeout <= $urandom;
      @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.action  <= a;
    cmd_if.slot    <= s;
    cmd_if.timeout <= t;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    model_r = predict_response(a, s, t);
    pending_results.push_back(typed ? want : model_r);
  endtask

  // Stop offering and wait until every expected response has arrived
  task automatic drain_responses();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Period write, only with the block idle
  task automatic write_period(logic [PERIOD_W-1:0] v);
    drain_responses();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_period = v;
  endtask

  // Response checker
  watch_result_t want_r;
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("response transfer with no expected response pending");
        error_count++;
      end else begin
        want_r = pending_results.pop_front();
        if (rsp_if.register_ok !== want_r.register_ok) begin
          $error("register_ok: expected %0d, got %0d", want_r.register_ok,
                 rsp_if.register_ok);
          error_count++;
        end
        if (rsp_if.assigned_slot !== want_r.assigned_slot) begin
          $error("assigned_slot: expected %0d, got %0d", want_r.assigned_slot,
                 rsp_if.assigned_slot);
          error_count++;
        end
        if (rsp_if.expired !== want_r.expired) begin
          $error("expired: expected %0d, got %0d", want_r.expired, rsp_if.expired);
          error_count++;
        end
        if (rsp_if.expired_slot !== want_r.expired_slot) begin
          $error("expired_slot: expected %0d, got %0d", want_r.expired_slot,
                 rsp_if.expired_slot);
          error_count++;
        end
        if (rsp_if.expired_elapsed !== want_r.expired_elapsed) begin
          $error("expired_elapsed: expected %0d, got %0d", want_r.expired_elapsed,
                 rsp_if.expired_elapsed);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, ready held during steady part
  initial begin
    int cyc;
    int hold;
    cyc = 0;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 2500) hold = 300;
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 36);
      end
    end
  end

  // Timeout: cycles with no transfer and no period write
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
        stall = 0;
      else
        stall++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin
    int n;
    int ph;
    int k;
    int r;
    int pick;
    int reg_pct;
    logic [ACTION_W-1:0] a;
    logic [SLOT_W-1:0]   s;
    logic [TIME_W-1:0]   t;
    logic [PERIOD_W-1:0] periods [NUM_PHASES];

    periods = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd1000, 16'd5, 16'd1, 16'd17};
    error_count = 0;
    steady = 0;
    now_ms = '0;
    ticks_since_scan = '0;
    scan_period = PERIOD_RESET;
    for (k = 0; k < NUM_SLOTS; k++) begin
      live[k] = 0;
      limit_ticks[k] = '0;
      fed_at[k] = '0;
    end

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    cmd_if.valid   <= 1'b0;
    cmd_if.action  <= ACT_TICK;
    cmd_if.slot    <= '0;
    cmd_if.timeout <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table; typed expectations only where obvious
    // after reset: tick with no scan, feed and unregister of idle slots
    directed_rows.push_back(row(0, 0, ACT_TICK, 0, 0, 1, 1, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_FEED, 0, 0, 1, 1, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_UNREG, 15, 0, 1, 1, NO_EVENT));
    // timeout extremes
    directed_rows.push_back(row(0, 0, ACT_REGISTER, 0, 32'd0, 1, 1, granted(0)));
    directed_rows.push_back(row(0, 0, ACT_REGISTER, 0, 32'hFFFF_FFFF, 1, 1,
                                granted(1)));
    directed_rows.push_back(row(0, 0, ACT_TICK, 0, 0, 2, 0, NO_EVENT));
    // period lowered below the running count: next tick scans
    directed_rows.push_back(row(1, 2, ACT_TICK, 0, 0, 0, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_TICK, 0, 0, 1, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_FEED, 0, 0, 1, 1, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_TICK, 0, 0, 2, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_UNREG, 0, 0, 1, 1, NO_EVENT));
    // period zero scans on every tick
    directed_rows.push_back(row(1, 0, ACT_TICK, 0, 0, 0, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_TICK, 0, 0, 1, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_REGISTER, 0, 32'd3, 1, 1, granted(0)));
    // fill the table, then register into a full table
    directed_rows.push_back(row(0, 0, ACT_REGISTER, 0, 32'd100, 14, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_REGISTER, 0, 32'd7, 1, 1, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_FEED, 15, 0, 1, 1, NO_EVENT));
    // unfed slot keeps expiring on later scans
    directed_rows.push_back(row(0, 0, ACT_TICK, 0, 0, 5, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_UNREG, 15, 0, 1, 1, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_REGISTER, 0, 32'd0, 1, 1, granted(15)));
    directed_rows.push_back(row(1, 16'd65535, ACT_TICK, 0, 0, 0, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_TICK, 0, 0, 1, 1, NO_EVENT));
    directed_rows.push_back(row(1, 1, ACT_TICK, 0, 0, 0, 0, NO_EVENT));
    directed_rows.push_back(row(0, 0, ACT_TICK, 0, 0, 1, 0, NO_EVENT));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_period(directed_rows[i].period);
      end else begin
        for (r = 0; r < directed_rows[i].reps; r++)
          send_cmd(directed_rows[i].action, directed_rows[i].slot,
                   directed_rows[i].timeout, directed_rows[i].typed,
                   directed_rows[i].want);
      end
    end

    // Random phases, each with its own scan period setting
    n = 0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_period(periods[ph]);
      reg_pct = (ph % 3 == 0) ? 35 : 20;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        steady = (n >= 300 && n < 450);
        if (n == 600) drain_responses();
        pick = $urandom_range(99);
        if (pick < 40)
          a = ACT_TICK;
        else if (pick < 40 + reg_pct)
          a = ACT_REGISTER;
        else if (pick < 80)
          a = ACT_FEED;
        else
          a = ACT_UNREG;
        s = SLOT_W'($urandom_range(NUM_SLOTS - 1));
        // timeouts mostly short so that expiries happen
        pick = $urandom_range(99);
        if (pick < 60)
          t = $urandom_range(30);
        else if (pick < 75)
          t = $urandom_range(300);
        else if (pick < 85)
          t = '0;
        else if (pick < 90)
          t = '1;
        else
          t = $urandom;
        send_cmd(a, s, t, 0, NO_EVENT);
        n++;
      end
    end
    steady = 0;

    drain_responses();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/wdg_pkg.sv
design/wdg_in_if.sv
design/wdg_out_if.sv
design/wdg_ram.sv
design/wdg_slot_table.sv
design/multi_slot_task_watchdog.sv
sim/tb_multi_slot_task_watchdog.sv
